[sv/box_outline_quad_generator_core_macros.svh]
// Assertion macros for the box outline quad generator checker.
// Expects signals named clock and reset in the scope of use.
`ifndef BOX_OUTLINE_QUAD_GENERATOR_CORE_MACROS_SVH
`define BOX_OUTLINE_QUAD_GENERATOR_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BOQG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent, outside reset.
`define BOQG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/boqg_pkg.sv]
// Shared types, constants and saturating arithmetic for the box outline quad generator.
// No dependencies; the other source files, the macros header apart, refer to it by scoped names.
`default_nettype none

package boqg_pkg;

   localparam int COORD_W      = 32;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int MAG_W        = 21;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int SIZE_W       = 13;
   localparam int NUM_AXES     = 3;
   localparam int QUAD_COUNT   = 24;
   localparam int QIDX_W       = $clog2(QUAD_COUNT);
   localparam int QUADS_PER_AXIS = QUAD_COUNT / NUM_AXES;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PEND_W       = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [1:0]                axis_type;
   typedef logic [SIZE_W-1:0]         size_type;

   localparam axis_type AXIS_Y = 2'd0;
   localparam axis_type AXIS_X = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   // camera-to-corner difference of 32.0 or more on any axis counts as far
   localparam logic signed [DIFF_W-1:0] NEAR_LIM     = 33'sd2097152;
   localparam logic signed [DIFF_W-1:0] NEAR_LIM_NEG = -33'sd2097152;

   // squared distance thresholds in Q32.32
   localparam logic [DIST_W-1:0] DIST_4    = 44'h004_0000_0000;
   localparam logic [DIST_W-1:0] DIST_16   = 44'h010_0000_0000;
   localparam logic [DIST_W-1:0] DIST_64   = 44'h040_0000_0000;
   localparam logic [DIST_W-1:0] DIST_256  = 44'h100_0000_0000;
   localparam logic [DIST_W-1:0] DIST_1024 = 44'h400_0000_0000;

   localparam size_type OFS_FAR  = 13'd655;
   localparam size_type OFS_MID  = 13'd410;
   localparam size_type OFS_NEAR = 13'd328;

   localparam size_type EDGE_1  = 13'd4096;
   localparam size_type EDGE_2  = 13'd2048;
   localparam size_type EDGE_4  = 13'd1024;
   localparam size_type EDGE_6  = 13'd683;
   localparam size_type EDGE_8  = 13'd512;
   localparam size_type EDGE_12 = 13'd341;

   // grown box and edge width, one queue entry; index 0 x, 1 y, 2 z
   typedef struct packed {
      coord_type [NUM_AXES-1:0] lo;
      coord_type [NUM_AXES-1:0] hi;
      size_type                 size;
   } box_type;

   typedef struct packed {
      axis_type  plane_axis;
      coord_type plane_value;
      coord_type first_u;
      coord_type first_v;
      coord_type second_u;
      coord_type second_v;
      logic      last_quad;
   } quad_type;

   // a + s or a - s, clamped to the signed 32-bit range
   function automatic coord_type sat_step(input coord_type a, input size_type s,
                                          input logic neg);
      logic signed [DIFF_W-1:0] ext_a;
      logic signed [DIFF_W-1:0] ext_s;
      logic signed [DIFF_W-1:0] t;
      coord_type                r;
      ext_a = {a[COORD_W-1], a};
      ext_s = {{(DIFF_W-SIZE_W){1'b0}}, s};
      t     = neg ? (ext_a - ext_s) : (ext_a + ext_s);
      if (t[DIFF_W-1] != t[DIFF_W-2]) begin
         r = t[DIFF_W-1] ? COORD_MIN : COORD_MAX;
      end else begin
         r = t[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/boqg_if.sv]
// Valid/ready channel interfaces for box words and quad words.
// Depends on boqg_pkg for the coordinate and axis types.
`default_nettype none

interface boqg_req_if;
   logic                valid;
   logic                ready;
   boqg_pkg::coord_type cam_x;
   boqg_pkg::coord_type cam_y;
   boqg_pkg::coord_type cam_z;
   boqg_pkg::coord_type min_x;
   boqg_pkg::coord_type min_y;
   boqg_pkg::coord_type min_z;
   boqg_pkg::coord_type max_x;
   boqg_pkg::coord_type max_y;
   boqg_pkg::coord_type max_z;

   modport source (output valid, cam_x, cam_y, cam_z, min_x, min_y, min_z,
                   max_x, max_y, max_z, input ready);
   modport sink   (input valid, cam_x, cam_y, cam_z, min_x, min_y, min_z,
                   max_x, max_y, max_z, output ready);
endinterface

interface boqg_rsp_if;
   logic                valid;
   logic                ready;
   boqg_pkg::axis_type  plane_axis;
   boqg_pkg::coord_type plane_value;
   boqg_pkg::coord_type first_u;
   boqg_pkg::coord_type first_v;
   boqg_pkg::coord_type second_u;
   boqg_pkg::coord_type second_v;
   logic                last_quad;

   modport source (output valid, plane_axis, plane_value, first_u, first_v,
                   second_u, second_v, last_quad, input ready);
   modport sink   (input valid, plane_axis, plane_value, first_u, first_v,
                   second_u, second_v, last_quad, output ready);
endinterface

`default_nettype wire

[sv/boqg_front.sv]
// Front end: accepts box words, forms the squared camera distance, picks offset and
// edge width and grows the box. Three stages; depends on boqg_pkg and boqg_if.
`default_nettype none

module boqg_front (
   input  wire logic         clock,
   input  wire logic         reset,
   boqg_req_if.sink          req_chan,
   output logic              push_valid,
   input  wire logic         push_ready,
   output boqg_pkg::box_type push_box
);

   boqg_pkg::coord_type cam_in [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type mn_in  [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type mx_in  [boqg_pkg::NUM_AXES];

   logic signed [boqg_pkg::DIFF_W-1:0] diff     [boqg_pkg::NUM_AXES];
   logic [boqg_pkg::DIFF_W-1:0]        mag_full [boqg_pkg::NUM_AXES];
   logic [boqg_pkg::NUM_AXES-1:0]      far_axis;

   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic s1_rdy, s2_rdy, s3_rdy, s1_load, s2_load, s3_load;

   logic                      s1_far_ff;
   logic [boqg_pkg::MAG_W-1:0] s1_mag_ff [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type        s1_mn_ff  [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type        s1_mx_ff  [boqg_pkg::NUM_AXES];

   logic                      s2_far_ff;
   logic [boqg_pkg::SQ_W-1:0] s2_sq_ff [boqg_pkg::NUM_AXES];
   logic [boqg_pkg::SQ_W-1:0] s2_sq_in [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type       s2_mn_ff [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type       s2_mx_ff [boqg_pkg::NUM_AXES];

   logic                        s3_far_ff;
   logic [boqg_pkg::DIST_W-1:0] s3_dist_ff, s3_dist_in;
   boqg_pkg::coord_type         s3_mn_ff [boqg_pkg::NUM_AXES];
   boqg_pkg::coord_type         s3_mx_ff [boqg_pkg::NUM_AXES];

   boqg_pkg::size_type ofs, edge_w;

   assign cam_in[0] = req_chan.cam_x;
   assign cam_in[1] = req_chan.cam_y;
   assign cam_in[2] = req_chan.cam_z;
   assign mn_in[0]  = req_chan.min_x;
   assign mn_in[1]  = req_chan.min_y;
   assign mn_in[2]  = req_chan.min_z;
   assign mx_in[0]  = req_chan.max_x;
   assign mx_in[1]  = req_chan.max_y;
   assign mx_in[2]  = req_chan.max_z;

   always_comb begin
      for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
         diff[i]     = {cam_in[i][boqg_pkg::COORD_W-1], cam_in[i]}
                     - {mn_in[i][boqg_pkg::COORD_W-1], mn_in[i]};
         far_axis[i] = (diff[i] >= boqg_pkg::NEAR_LIM) || (diff[i] <= boqg_pkg::NEAR_LIM_NEG);
         mag_full[i] = diff[i][boqg_pkg::DIFF_W-1] ? -diff[i] : diff[i];
      end
   end

   // stall chain: a stage takes a word when it is empty or its word moves on
   assign s3_rdy  = !s3_v_ff || push_ready;
   assign s2_rdy  = !s2_v_ff || s3_rdy;
   assign s1_rdy  = !s1_v_ff || s2_rdy;
   assign s1_load = req_chan.valid && s1_rdy;
   assign s2_load = s1_v_ff && s2_rdy;
   assign s3_load = s2_v_ff && s3_rdy;
   assign s1_v_in = s1_load || (s1_v_ff && !s2_rdy);
   assign s2_v_in = s2_load || (s2_v_ff && !s3_rdy);
   assign s3_v_in = s3_load || (s3_v_ff && !push_ready);

   assign req_chan.ready = s1_rdy;
   assign push_valid     = s3_v_ff;

   always_comb begin
      for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
         s2_sq_in[i] = s1_mag_ff[i] * s1_mag_ff[i];
      end
   end

   assign s3_dist_in = boqg_pkg::DIST_W'(s2_sq_ff[0]) + boqg_pkg::DIST_W'(s2_sq_ff[1])
                     + boqg_pkg::DIST_W'(s2_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_far_ff <= |far_axis;
         for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
            s1_mag_ff[i] <= mag_full[i][boqg_pkg::MAG_W-1:0];
            s1_mn_ff[i]  <= mn_in[i];
            s1_mx_ff[i]  <= mx_in[i];
         end
      end
      if (s2_load) begin
         s2_far_ff <= s1_far_ff;
         for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
            s2_sq_ff[i] <= s2_sq_in[i];
            s2_mn_ff[i] <= s1_mn_ff[i];
            s2_mx_ff[i] <= s1_mx_ff[i];
         end
      end
      if (s3_load) begin
         s3_far_ff  <= s2_far_ff;
         s3_dist_ff <= s3_dist_in;
         for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
            s3_mn_ff[i] <= s2_mn_ff[i];
            s3_mx_ff[i] <= s2_mx_ff[i];
         end
      end
   end

   // far camera keeps the widest offset and edge
   always_comb begin
      ofs    = boqg_pkg::OFS_FAR;
      edge_w = boqg_pkg::EDGE_1;
      if (!s3_far_ff) begin
         if (s3_dist_ff < boqg_pkg::DIST_4) begin
            ofs    = boqg_pkg::OFS_NEAR;
            edge_w = boqg_pkg::EDGE_12;
         end else if (s3_dist_ff < boqg_pkg::DIST_16) begin
            ofs    = boqg_pkg::OFS_MID;
            edge_w = boqg_pkg::EDGE_8;
         end else if (s3_dist_ff < boqg_pkg::DIST_64) begin
            edge_w = boqg_pkg::EDGE_6;
         end else if (s3_dist_ff < boqg_pkg::DIST_256) begin
            edge_w = boqg_pkg::EDGE_4;
         end else if (s3_dist_ff < boqg_pkg::DIST_1024) begin
            edge_w = boqg_pkg::EDGE_2;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < boqg_pkg::NUM_AXES; i++) begin
         push_box.lo[i] = boqg_pkg::sat_step(s3_mn_ff[i], ofs, 1'b1);
         push_box.hi[i] = boqg_pkg::sat_step(s3_mx_ff[i], ofs, 1'b0);
      end
      push_box.size = edge_w;
   end

endmodule

`default_nettype wire

[sv/boqg_queue.sv]
// Short queue of grown boxes between the front end and the quad sequencer.
// Depends on boqg_pkg for the entry type and depth.
`default_nettype none

module boqg_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire boqg_pkg::box_type push_box,
   input  wire logic              pop,
   output logic                   head_valid,
   output boqg_pkg::box_type      head_box
);

   boqg_pkg::box_type entry_ff [boqg_pkg::QUEUE_DEPTH];

   logic [boqg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [boqg_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        push;

   assign push_ready = cnt_ff != boqg_pkg::QCNT_W'(boqg_pkg::QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_box   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == boqg_pkg::QPTR_W'(boqg_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == boqg_pkg::QPTR_W'(boqg_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_box;
      end
   end

endmodule

`default_nettype wire

[sv/boqg_back.sv]
// Back end: walks the edge strips of the box at the queue head into a registered output
// word, one quad a cycle unless the output stalls. Depends on boqg_pkg and boqg_if.
`default_nettype none

module boqg_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire boqg_pkg::box_type head_box,
   output logic                   pop,
   boqg_rsp_if.source             rsp_chan
);

   localparam logic [2:0] FACE_BOTTOM = 3'd0;
   localparam logic [2:0] FACE_TOP    = 3'd1;
   localparam logic [2:0] FACE_LEFT   = 3'd2;
   localparam logic [2:0] FACE_RIGHT  = 3'd3;
   localparam logic [2:0] FACE_FRONT  = 3'd4;
   localparam logic [2:0] FACE_BACK   = 3'd5;

   localparam logic [1:0] STRIP_LOW_U  = 2'd0;
   localparam logic [1:0] STRIP_HIGH_U = 2'd1;
   localparam logic [1:0] STRIP_LOW_V  = 2'd2;
   localparam logic [1:0] STRIP_HIGH_V = 2'd3;

   logic [boqg_pkg::QIDX_W-1:0] idx_ff, idx_in;
   logic                        out_v_ff, out_v_in;
   boqg_pkg::quad_type          out_q_ff, quad;
   logic                        load, last;
   logic [2:0]                  face;
   logic [1:0]                  strip;

   boqg_pkg::axis_type  axis;
   boqg_pkg::coord_type plane, a1, a2, b1, b2, a1s, a2s, b1s, b2s;

   assign face  = idx_ff[boqg_pkg::QIDX_W-1:2];
   assign strip = idx_ff[1:0];
   assign last  = idx_ff == boqg_pkg::QIDX_W'(boqg_pkg::QUAD_COUNT - 1);
   assign load  = head_valid && (!out_v_ff || rsp_chan.ready);
   assign pop   = load && last;

   always_comb begin
      unique case (face)
         FACE_BOTTOM, FACE_TOP: begin
            axis  = boqg_pkg::AXIS_Y;
            plane = (face == FACE_TOP) ? head_box.hi[1] : head_box.lo[1];
            a1 = head_box.lo[0];
            a2 = head_box.hi[0];
            b1 = head_box.lo[2];
            b2 = head_box.hi[2];
         end
         FACE_LEFT, FACE_RIGHT: begin
            axis  = boqg_pkg::AXIS_X;
            plane = (face == FACE_RIGHT) ? head_box.hi[0] : head_box.lo[0];
            a1 = head_box.lo[2];
            a2 = head_box.hi[2];
            b1 = head_box.lo[1];
            b2 = head_box.hi[1];
         end
         FACE_FRONT, FACE_BACK: begin
            axis  = boqg_pkg::AXIS_Z;
            plane = (face == FACE_BACK) ? head_box.hi[2] : head_box.lo[2];
            a1 = head_box.lo[0];
            a2 = head_box.hi[0];
            b1 = head_box.lo[1];
            b2 = head_box.hi[1];
         end
         default: begin
            axis  = boqg_pkg::AXIS_Y;
            plane = head_box.lo[1];
            a1 = head_box.lo[0];
            a2 = head_box.hi[0];
            b1 = head_box.lo[2];
            b2 = head_box.hi[2];
         end
      endcase
   end

   assign a1s = boqg_pkg::sat_step(a1, head_box.size, 1'b0);
   assign a2s = boqg_pkg::sat_step(a2, head_box.size, 1'b1);
   assign b1s = boqg_pkg::sat_step(b1, head_box.size, 1'b0);
   assign b2s = boqg_pkg::sat_step(b2, head_box.size, 1'b1);

   always_comb begin
      quad.plane_axis  = axis;
      quad.plane_value = plane;
      quad.last_quad   = last;
      unique case (strip)
         STRIP_LOW_U: begin
            quad.first_u  = a1;
            quad.first_v  = b1s;
            quad.second_u = a1s;
            quad.second_v = b2s;
         end
         STRIP_HIGH_U: begin
            quad.first_u  = a2;
            quad.first_v  = b1s;
            quad.second_u = a2s;
            quad.second_v = b2s;
         end
         STRIP_LOW_V: begin
            quad.first_u  = a1;
            quad.first_v  = b1;
            quad.second_u = a2;
            quad.second_v = b1s;
         end
         STRIP_HIGH_V: begin
            quad.first_u  = a1;
            quad.first_v  = b2;
            quad.second_u = a2;
            quad.second_v = b2s;
         end
         default: begin
            quad.first_u  = a1;
            quad.first_v  = b1s;
            quad.second_u = a1s;
            quad.second_v = b2s;
         end
      endcase
   end

   // advance the strip counter on every loaded word, wrap after the last
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
      out_v_in = load || (out_v_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_q_ff <= quad;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.plane_axis  = out_q_ff.plane_axis;
   assign rsp_chan.plane_value = out_q_ff.plane_value;
   assign rsp_chan.first_u     = out_q_ff.first_u;
   assign rsp_chan.first_v     = out_q_ff.first_v;
   assign rsp_chan.second_u    = out_q_ff.second_u;
   assign rsp_chan.second_v    = out_q_ff.second_v;
   assign rsp_chan.last_quad   = out_q_ff.last_quad;

endmodule

`default_nettype wire

[sv/box_outline_quad_generator_core.sv]
// Channel    Dir  Word                               Handshake
// req_chan   in   camera, box min corner, max corner valid/ready
// rsp_chan   out  one edge-strip quad, last flag     valid/ready
//
// The front end takes a box word every cycle while its three stages and the two-entry
// queue have room; boxes pass the stages and the queue, quads the output register.
// The sequencer sends one quad a cycle while the output is taken; a box gives one quad per edge strip.
// Reset (synchronous, active high) empties the stages, the queue and the output register.
// Either side may stall at any time; nothing is dropped or repeated.
// Top level of the box outline quad generator; depends on boqg_pkg, boqg_if and submodules.
`default_nettype none

module box_outline_quad_generator_core (
   input  wire logic clock,
   input  wire logic reset,
   boqg_req_if.sink  req_chan,
   boqg_rsp_if.source rsp_chan
);

   logic              push_valid, push_ready, head_valid, pop;
   boqg_pkg::box_type push_box, head_box;

   boqg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_box   (push_box)
   );

   boqg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_box   (push_box),
      .pop        (pop),
      .head_valid (head_valid),
      .head_box   (head_box)
   );

   boqg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_box   (head_box),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/boqg_checker.sv]
// Port-level checker for the box outline quad generator, bound to the top level.
// Depends on boqg_pkg and the assertion macros header.
`default_nettype none

`include "box_outline_quad_generator_core_macros.svh"

module boqg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire boqg_pkg::axis_type rsp_plane_axis,
   input wire logic               rsp_last_quad
);

   logic [boqg_pkg::QIDX_W-1:0] quad_cnt_ff, quad_cnt_in;
   logic [boqg_pkg::PEND_W-1:0] pend_ff, pend_in;
   boqg_pkg::axis_type          exp_axis;
   logic                        exp_last;
   logic                        req_take, rsp_take, rsp_end;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign rsp_end  = rsp_take && rsp_last_quad;
   assign exp_last = quad_cnt_ff == boqg_pkg::QIDX_W'(boqg_pkg::QUAD_COUNT - 1);

   always_comb begin
      quad_cnt_in = quad_cnt_ff;
      if (rsp_take) begin
         quad_cnt_in = (quad_cnt_ff == boqg_pkg::QIDX_W'(boqg_pkg::QUAD_COUNT - 1))
                     ? '0 : quad_cnt_ff + 1'b1;
      end
      pend_in = pend_ff;
      if (req_take && !rsp_end) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_end && !req_take) begin
         pend_in = pend_ff - 1'b1;
      end
      if (quad_cnt_ff < boqg_pkg::QIDX_W'(boqg_pkg::QUADS_PER_AXIS)) begin
         exp_axis = boqg_pkg::AXIS_Y;
      end else if (quad_cnt_ff < boqg_pkg::QIDX_W'(2 * boqg_pkg::QUADS_PER_AXIS)) begin
         exp_axis = boqg_pkg::AXIS_X;
      end else begin
         exp_axis = boqg_pkg::AXIS_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_cnt_ff <= '0;
         pend_ff     <= '0;
      end else begin
         quad_cnt_ff <= quad_cnt_in;
         pend_ff     <= pend_in;
      end
   end

   `BOQG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "quad word withdrawn")
   `BOQG_ASSERT(a_last_flag, rsp_valid |-> (rsp_last_quad == exp_last), "last flag out of step")
   `BOQG_ASSERT(a_axis_order, rsp_valid |-> (rsp_plane_axis == exp_axis), "axis out of order")
   `BOQG_ASSERT(a_no_orphan, rsp_valid |-> (pend_ff != '0), "quad word with no box pending")

endmodule

bind box_outline_quad_generator_core boqg_checker u_boqg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_plane_axis (rsp_chan.plane_axis),
   .rsp_last_quad  (rsp_chan.last_quad)
);

`default_nettype wire

[verif/box_outline_quad_generator_core_tb.sv]
// Testbench for box_outline_quad_generator_core: drives box words, predicts the edge-strip
// quads of each box and checks every quad word in order, with random idling on both sides.
// Depends on boqg_pkg, boqg_if and the block's RTL.

module box_outline_quad_generator_core_tb;

   localparam int IDLE_PCT     = 29;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 32;
   localparam int STALL_CYCLES = 300;

   localparam longint NEAR_SPAN = 64'sd2097152;
   localparam longint SAT_HI    = 64'sd2147483647;
   localparam longint SAT_LO    = -64'sd2147483648;

   localparam logic [63:0] DIST_SQ_4    = 64'h0000_0004_0000_0000;
   localparam logic [63:0] DIST_SQ_16   = 64'h0000_0010_0000_0000;
   localparam logic [63:0] DIST_SQ_64   = 64'h0000_0040_0000_0000;
   localparam logic [63:0] DIST_SQ_256  = 64'h0000_0100_0000_0000;
   localparam logic [63:0] DIST_SQ_1024 = 64'h0000_0400_0000_0000;

   localparam longint GROW_FAR  = 655;
   localparam longint GROW_MID  = 410;
   localparam longint GROW_NEAR = 328;

   // index 0 x, 1 y, 2 z
   typedef struct {
      boqg_pkg::coord_type cam[3];
      boqg_pkg::coord_type lo[3];
      boqg_pkg::coord_type hi[3];
   } box_word_type;

   logic clock = 1'b0;
   logic reset;

   boqg_req_if req_chan ();
   boqg_rsp_if rsp_chan ();

   box_outline_quad_generator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   boqg_pkg::quad_type quads_due[$];
   int       mismatches   = 0;
   int       boxes_sent   = 0;
   int       quads_seen   = 0;
   int       near_boxes   = 0;
   int       mid_boxes    = 0;
   int       far_boxes    = 0;
   int       hold_request = 0;
   int       hold_left    = 0;
   int       cycles_run   = 0;
   bit       calm         = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   function automatic boqg_pkg::coord_type clamp32(input longint v);
      if (v > SAT_HI) begin
         return boqg_pkg::coord_type'(SAT_HI);
      end
      if (v < SAT_LO) begin
         return boqg_pkg::coord_type'(SAT_LO);
      end
      return boqg_pkg::coord_type'(v);
   endfunction

   function automatic void push_quad(input boqg_pkg::axis_type ax,
                                     input boqg_pkg::coord_type plane,
                                     input boqg_pkg::coord_type u1,
                                     input boqg_pkg::coord_type v1,
                                     input boqg_pkg::coord_type u2,
                                     input boqg_pkg::coord_type v2,
                                     input bit last);
      boqg_pkg::quad_type q;
      q.plane_axis  = ax;
      q.plane_value = plane;
      q.first_u     = u1;
      q.first_v     = v1;
      q.second_u    = u2;
      q.second_v    = v2;
      q.last_quad   = last;
      quads_due.push_back(q);
   endfunction

   // four strips of one face: low u, high u, low v, high v
   function automatic void push_face(input boqg_pkg::axis_type ax,
                                     input boqg_pkg::coord_type plane,
                                     input boqg_pkg::coord_type a1,
                                     input boqg_pkg::coord_type a2,
                                     input boqg_pkg::coord_type b1,
                                     input boqg_pkg::coord_type b2,
                                     input longint w, input bit closing);
      boqg_pkg::coord_type a1s;
      boqg_pkg::coord_type a2s;
      boqg_pkg::coord_type b1s;
      boqg_pkg::coord_type b2s;
      a1s = clamp32(longint'(a1) + w);
      a2s = clamp32(longint'(a2) - w);
      b1s = clamp32(longint'(b1) + w);
      b2s = clamp32(longint'(b2) - w);
      push_quad(ax, plane, a1, b1s, a1s, b2s, 1'b0);
      push_quad(ax, plane, a2, b1s, a2s, b2s, 1'b0);
      push_quad(ax, plane, a1, b1, a2, b1s, 1'b0);
      push_quad(ax, plane, a1, b2, a2, b2s, closing);
   endfunction

   function automatic void predict_outline(input box_word_type b);
      longint              d;
      logic [63:0]         dist_sq;
      bit                  far_away;
      longint              grow;
      longint              strip_w;
      boqg_pkg::coord_type p1[3];
      boqg_pkg::coord_type p2[3];
      int                  i;
      dist_sq  = '0;
      far_away = 1'b0;
      for (i = 0; i < 3; i++) begin
         d = longint'(b.cam[i]) - longint'(b.lo[i]);
         if (d >= NEAR_SPAN || d <= -NEAR_SPAN) begin
            far_away = 1'b1;
         end else begin
            dist_sq += 64'(d * d);
         end
      end
      grow    = GROW_FAR;
      strip_w = 4096;
      if (!far_away) begin
         if (dist_sq < DIST_SQ_16)   grow = GROW_MID;
         if (dist_sq < DIST_SQ_4)    grow = GROW_NEAR;
         if (dist_sq < DIST_SQ_1024) strip_w = 2048;
         if (dist_sq < DIST_SQ_256)  strip_w = 1024;
         if (dist_sq < DIST_SQ_64)   strip_w = 683;
         if (dist_sq < DIST_SQ_16)   strip_w = 512;
         if (dist_sq < DIST_SQ_4)    strip_w = 341;
      end
      if (grow == GROW_NEAR) near_boxes++;
      else if (grow == GROW_MID) mid_boxes++;
      else far_boxes++;
      for (i = 0; i < 3; i++) begin
         p1[i] = clamp32(longint'(b.lo[i]) - grow);
         p2[i] = clamp32(longint'(b.hi[i]) + grow);
      end
      push_face(boqg_pkg::AXIS_Y, p1[1], p1[0], p2[0], p1[2], p2[2], strip_w, 1'b0);
      push_face(boqg_pkg::AXIS_Y, p2[1], p1[0], p2[0], p1[2], p2[2], strip_w, 1'b0);
      push_face(boqg_pkg::AXIS_X, p1[0], p1[2], p2[2], p1[1], p2[1], strip_w, 1'b0);
      push_face(boqg_pkg::AXIS_X, p2[0], p1[2], p2[2], p1[1], p2[1], strip_w, 1'b0);
      push_face(boqg_pkg::AXIS_Z, p1[2], p1[0], p2[0], p1[1], p2[1], strip_w, 1'b0);
      push_face(boqg_pkg::AXIS_Z, p2[2], p1[0], p2[0], p1[1], p2[1], strip_w, 1'b1);
   endfunction

   // ---------------- driving ----------------

   // enter and leave at a falling edge; valid stays high for a following word
   task automatic send_box(input box_word_type b);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_chan.cam_x = b.cam[0];
      req_chan.cam_y = b.cam[1];
      req_chan.cam_z = b.cam[2];
      req_chan.min_x = b.lo[0];
      req_chan.min_y = b.lo[1];
      req_chan.min_z = b.lo[2];
      req_chan.max_x = b.hi[0];
      req_chan.max_y = b.hi[1];
      req_chan.max_z = b.hi[2];
      req_chan.valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      predict_outline(b);
      boxes_sent++;
      @(negedge clock);
   endtask

   task automatic send_uniform(input boqg_pkg::coord_type cam, input boqg_pkg::coord_type lo,
                               input boqg_pkg::coord_type hi);
      box_word_type b;
      int           i;
      for (i = 0; i < 3; i++) begin
         b.cam[i] = cam;
         b.lo[i]  = lo;
         b.hi[i]  = hi;
      end
      send_box(b);
   endtask

   function automatic box_word_type random_box();
      box_word_type b;
      int           kind;
      int           i;
      longint       d;
      longint       span;
      kind = $urandom_range(0, 9);
      for (i = 0; i < 3; i++) begin
         if (kind < 7) begin
            // camera close to the min corner, spread over every distance band
            b.cam[i] = $urandom;
            d = $urandom_range(0, (1 << $urandom_range(0, 22)) - 1);
            if ($urandom_range(0, 1)) d = -d;
            b.lo[i] = boqg_pkg::coord_type'(longint'(b.cam[i]) - d);
            span = $urandom_range(0, 1 << $urandom_range(4, 24));
            if ($urandom_range(0, 9) == 0) span = -span;
            b.hi[i] = boqg_pkg::coord_type'(longint'(b.lo[i]) + span);
         end else if (kind < 9) begin
            b.cam[i] = $urandom;
            b.lo[i]  = $urandom;
            b.hi[i]  = $urandom;
         end else begin
            // hug the ends of the range so the grown box and strips clamp
            if ($urandom_range(0, 1)) begin
               b.lo[i] = boqg_pkg::coord_type'(SAT_LO + $urandom_range(0, 1000));
               b.hi[i] = boqg_pkg::coord_type'(SAT_HI - $urandom_range(0, 1000));
            end else begin
               b.lo[i] = boqg_pkg::coord_type'(SAT_HI - $urandom_range(0, 1000));
               b.hi[i] = boqg_pkg::coord_type'(SAT_LO + $urandom_range(0, 1000));
            end
            b.cam[i] = boqg_pkg::coord_type'(longint'(b.lo[i])
                                             + $urandom_range(0, 70000) - 35000);
         end
      end
      return b;
   endfunction

   // ---------------- result side ----------------

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_chan.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : quad_check
      boqg_pkg::quad_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         quads_seen++;
         if (quads_due.size() == 0) begin
            $error("quad word with no box outstanding: axis %0d plane %h",
                   rsp_chan.plane_axis, rsp_chan.plane_value);
            mismatches++;
         end else begin
            want = quads_due.pop_front();
            check_field("plane_axis",  want.plane_axis,  rsp_chan.plane_axis);
            check_field("plane_value", want.plane_value, rsp_chan.plane_value);
            check_field("first_u",     want.first_u,     rsp_chan.first_u);
            check_field("first_v",     want.first_v,     rsp_chan.first_v);
            check_field("second_u",    want.second_u,    rsp_chan.second_u);
            check_field("second_v",    want.second_v,    rsp_chan.second_v);
            check_field("last_quad",   want.last_quad,   rsp_chan.last_quad);
         end
      end
   end

   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Run stopped at the cycle limit with %0d quads outstanding", quads_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------- tests ----------------

   // camera offset along one axis, just under and exactly on each band boundary
   task automatic test_distance_bands();
      longint       steps[12];
      box_word_type b;
      int           i;
      int           ax;
      steps = '{131071, 131072, 262143, 262144, 524287, 524288,
                1048575, 1048576, 2097151, 2097152, -2097151, -2097152};
      for (i = 0; i < 12; i++) begin
         ax = i % 3;
         for (int j = 0; j < 3; j++) begin
            b.lo[j]  = 32'sh0010_0000;
            b.hi[j]  = 32'sh0012_0000;
            b.cam[j] = b.lo[j];
         end
         b.cam[ax] = boqg_pkg::coord_type'(longint'(b.lo[ax]) + steps[i]);
         send_box(b);
      end
      // spread over all three axes, either side of the nearest boundary
      send_uniform(32'sh0010_0000 + 75000, 32'sh0010_0000, 32'sh0011_0000);
      send_uniform(32'sh0010_0000 + 76000, 32'sh0010_0000, 32'sh0011_0000);
   endtask

   task automatic test_saturation_edges();
      send_uniform(boqg_pkg::COORD_MIN, boqg_pkg::COORD_MIN, boqg_pkg::COORD_MAX);
      send_uniform(boqg_pkg::COORD_MAX, boqg_pkg::COORD_MAX, boqg_pkg::COORD_MAX);
      send_uniform(boqg_pkg::COORD_MIN, boqg_pkg::COORD_MIN, boqg_pkg::COORD_MIN);
      send_uniform(boqg_pkg::COORD_MAX, boqg_pkg::COORD_MIN, boqg_pkg::COORD_MAX);
      send_uniform(boqg_pkg::COORD_MIN, boqg_pkg::COORD_MAX, boqg_pkg::COORD_MIN);
      send_uniform(32'sh0000_0000, 32'sh0064_0000, -32'sh0064_0000);
      send_uniform(32'sh0001_8000, 32'sh0001_8000, 32'sh0001_8000);
      send_uniform(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
      send_uniform(-32'sh1, -32'sh1, -32'sh1);
      send_uniform(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
   endtask

   task automatic test_random_boxes(input int count, input bit quiet);
      int n;
      calm = quiet;
      for (n = 0; n < count; n++) begin
         send_box(random_box());
      end
      calm = 1'b0;
   endtask

   // hold the output off while words keep coming, so the input has to stall
   task automatic test_output_stall();
      int n;
      hold_request = STALL_CYCLES;
      calm = 1'b1;
      for (n = 0; n < 10; n++) begin
         send_box(random_box());
      end
      calm = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.cam_x   = '0;
      req_chan.cam_y   = '0;
      req_chan.cam_z   = '0;
      req_chan.min_x   = '0;
      req_chan.min_y   = '0;
      req_chan.min_z   = '0;
      req_chan.max_x   = '0;
      req_chan.max_y   = '0;
      req_chan.max_z   = '0;
      rsp_chan.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_distance_bands();
      test_saturation_edges();
      test_random_boxes(25, 1'b0);
      test_random_boxes(20, 1'b1);
      test_output_stall();
      test_random_boxes(20, 1'b0);
      req_chan.valid = 1'b0;

      while (quads_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d boxes (%0d near, %0d mid, %0d far) and %0d quad words,",
               boxes_sent, near_boxes, mid_boxes, far_boxes, quads_seen);
      $display("with band boundaries, clamping, idling, a calm stretch and a long output stall");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/boqg_pkg.sv
sv/boqg_if.sv
sv/boqg_front.sv
sv/boqg_queue.sv
sv/boqg_back.sv
sv/box_outline_quad_generator_core.sv
sv/boqg_checker.sv
verif/box_outline_quad_generator_core_tb.sv
